[hw/rtl/sca_pkg.sv]
// Shared types and constants for the slot cache with arena fallback.
`default_nettype none

package sca_pkg;

    localparam int POOL_SLOTS_DEF = 32;

    localparam logic [15:0] TAG_BYTES = 16'd2;

    // opcodes
    localparam logic [1:0] OP_ALLOC_SLOT  = 2'd0;
    localparam logic [1:0] OP_ALLOC_ARENA = 2'd1;
    localparam logic [1:0] OP_FREE_SLOT   = 2'd2;

    // status codes
    localparam logic [2:0] ST_SLOT      = 3'd0;
    localparam logic [2:0] ST_ARENA     = 3'd1;
    localparam logic [2:0] ST_FREED     = 3'd2;
    localparam logic [2:0] ST_TOO_LARGE = 3'd3;
    localparam logic [2:0] ST_NO_BLOCKS = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_SLOTS_IN_USE = 3'd0;
    localparam logic [2:0] CFG_SLOT_BYTES   = 3'd1;
    localparam logic [2:0] CFG_BLOCK_BYTES  = 3'd2;
    localparam logic [2:0] CFG_HEADER_BYTES = 3'd3;
    localparam logic [2:0] CFG_MAX_BLOCKS   = 3'd4;

    // configuration reset values
    localparam logic [5:0]  RST_SLOTS_IN_USE = 6'd32;
    localparam logic [12:0] RST_SLOT_BYTES   = 13'd64;
    localparam logic [15:0] RST_BLOCK_BYTES  = 16'd65500;
    localparam logic [5:0]  RST_HEADER_BYTES = 6'd12;
    localparam logic [7:0]  RST_MAX_BLOCKS   = 8'd255;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] req_bytes;
        logic [4:0]  slot_index;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  slot;
        logic [7:0]  block_number;
        logic [15:0] byte_offset;
    } rsp_t;

endpackage

`default_nettype wire

[hw/rtl/slot_cache_with_arena_fallback_core.sv]
// Slot allocator with bitmap search and bump-arena fallback, one shared adder.
// Per request: a free goes straight to the result; a slot request scans from the hint and on a miss
// falls to the arena, which steps NEED, FIT (CAP, CAPCHK to open a block or reject), OFF, USED, BFREE.
// Throughput: one beat at a time; the next request is taken once the result is
// registered, so a stalled response beat holds the input. One slot tested per cycle.
// Reset: bitmap, hint and arena state clear; config registers take reset values.
`default_nettype none

module slot_cache_with_arena_fallback_core #(
    parameter int POOL_SLOTS = sca_pkg::POOL_SLOTS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output      logic          req_ready,
    input  wire sca_pkg::req_t req_data,
    output      logic          rsp_valid,
    input  wire logic          rsp_ready,
    output      sca_pkg::rsp_t rsp_data,
    input  wire logic          cfg_valid,
    output      logic          cfg_ready,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [15:0]   cfg_data
);
    import sca_pkg::*;

    localparam int HW = $clog2(POOL_SLOTS + 1);
    localparam int IW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam logic [6:0] NSLOTS7 = 7'(POOL_SLOTS);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1;
    localparam logic [3:0] S_NEED   = 4'd2;
    localparam logic [3:0] S_FIT    = 4'd3;
    localparam logic [3:0] S_CAP    = 4'd4;
    localparam logic [3:0] S_CAPCHK = 4'd5;
    localparam logic [3:0] S_OFF    = 4'd6;
    localparam logic [3:0] S_USED   = 4'd7;
    localparam logic [3:0] S_BFREE  = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    logic [3:0]            state_reg, state_next;
    logic [5:0]            slots_in_use_reg;
    logic [12:0]           slot_bytes_reg;
    logic [15:0]           block_bytes_reg;
    logic [5:0]            header_bytes_reg;
    logic [7:0]            max_blocks_reg;

    logic [POOL_SLOTS-1:0] in_use_map_reg, in_use_map_next;
    logic [HW-1:0]         hint_reg, hint_next;
    logic [HW-1:0]         scan_ptr_reg, scan_ptr_next;
    logic [15:0]           block_used_reg, block_used_next;
    logic [15:0]           block_free_reg, block_free_next;
    logic [7:0]            block_count_reg, block_count_next;

    logic [15:0]           bytes_reg, bytes_next;
    logic [16:0]           need_reg, need_next;
    logic [15:0]           cap_reg, cap_next;
    logic [15:0]           off_reg, off_next;
    rsp_t                  pend_reg, pend_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_t                  rsp_data_reg, rsp_data_next;

    // shared add/subtract unit
    logic [16:0]           alu_a, alu_b;
    logic                  alu_sub;
    logic [17:0]           alu_res;
    logic                  alu_borrow;

    logic [HW-1:0]         slot_count;
    logic                  scan_in_range;
    logic [IW-1:0]         scan_idx;
    logic                  scan_hit;
    logic [6:0]            scan_ptr7;
    logic [6:0]            free_idx7;

    assign req_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    assign slot_count    = ({1'b0, slots_in_use_reg} < NSLOTS7) ? HW'(slots_in_use_reg)
                                                                 : HW'(POOL_SLOTS);
    assign scan_in_range = (scan_ptr_reg < slot_count);
    assign scan_ptr7     = 7'(scan_ptr_reg);
    assign scan_idx      = scan_ptr7[IW-1:0];
    assign scan_hit      = (state_reg == S_SCAN) && scan_in_range && !in_use_map_reg[scan_idx];
    assign free_idx7     = 7'(req_data.slot_index);

    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            S_NEED:
            begin
                alu_a = {1'b0, bytes_reg};
                alu_b = {1'b0, TAG_BYTES};
            end
            S_FIT:
            begin
                alu_a   = {1'b0, block_free_reg};
                alu_b   = need_reg;
                alu_sub = 1'b1;
            end
            S_CAP:
            begin
                alu_a   = {1'b0, block_bytes_reg};
                alu_b   = 17'(header_bytes_reg);
                alu_sub = 1'b1;
            end
            S_CAPCHK:
            begin
                alu_a   = {1'b0, cap_reg};
                alu_b   = need_reg;
                alu_sub = 1'b1;
            end
            S_OFF:
            begin
                alu_a = {1'b0, block_used_reg};
                alu_b = {1'b0, TAG_BYTES};
            end
            S_USED:
            begin
                alu_a = {1'b0, block_used_reg};
                alu_b = need_reg;
            end
            S_BFREE:
            begin
                alu_a   = {1'b0, block_free_reg};
                alu_b   = need_reg;
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_sub = 1'b0;
            end
        endcase
    end

    assign alu_res    = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                                : ({1'b0, alu_a} + {1'b0, alu_b});
    assign alu_borrow = alu_res[17];

    always_comb
    begin
        state_next       = state_reg;
        in_use_map_next  = in_use_map_reg;
        hint_next        = hint_reg;
        scan_ptr_next    = scan_ptr_reg;
        block_used_next  = block_used_reg;
        block_free_next  = block_free_reg;
        block_count_next = block_count_reg;
        bytes_next       = bytes_reg;
        need_next        = need_reg;
        cap_next         = cap_reg;
        off_next         = off_reg;
        pend_next        = pend_reg;
        rsp_valid_next   = rsp_valid_reg;
        rsp_data_next    = rsp_data_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    pend_next  = '0;
                    bytes_next = req_data.req_bytes;
                    case (req_data.opcode)
                        OP_ALLOC_SLOT:
                        begin
                            scan_ptr_next = hint_reg;
                            state_next    = S_SCAN;
                        end
                        OP_ALLOC_ARENA:
                        begin
                            state_next = S_NEED;
                        end
                        OP_FREE_SLOT:
                        begin
                            if (free_idx7 < NSLOTS7)
                            begin
                                in_use_map_next[free_idx7[IW-1:0]] = 1'b0;
                            end
                            if (free_idx7 < 7'(hint_reg))
                            begin
                                hint_next = HW'(req_data.slot_index);
                            end
                            pend_next.status = ST_FREED;
                            state_next       = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_IDLE;  // unused opcode: no result
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (!scan_in_range)
                begin
                    hint_next  = slot_count;
                    bytes_next = 16'(slot_bytes_reg);
                    state_next = S_NEED;
                end
                else if (scan_hit)
                begin
                    in_use_map_next[scan_idx] = 1'b1;
                    hint_next                 = scan_ptr_reg + HW'(1);
                    pend_next.status          = ST_SLOT;
                    pend_next.slot            = scan_ptr7[4:0];
                    state_next                = S_DONE;
                end
                else
                begin
                    scan_ptr_next = scan_ptr_reg + HW'(1);
                end
            end
            S_NEED:
            begin
                need_next  = alu_res[16:0];
                state_next = S_FIT;
            end
            S_FIT:
            begin
                // borrow means the request does not fit the open block
                state_next = alu_borrow ? S_CAP : S_OFF;
            end
            S_CAP:
            begin
                cap_next   = alu_borrow ? 16'd0 : alu_res[15:0];
                state_next = S_CAPCHK;
            end
            S_CAPCHK:
            begin
                if (alu_borrow)
                begin
                    pend_next.status = ST_TOO_LARGE;
                    state_next       = S_DONE;
                end
                else if (block_count_reg >= max_blocks_reg)
                begin
                    pend_next.status = ST_NO_BLOCKS;
                    state_next       = S_DONE;
                end
                else
                begin
                    block_count_next = block_count_reg + 8'd1;
                    block_used_next  = 16'(header_bytes_reg);
                    block_free_next  = cap_reg;
                    state_next       = S_OFF;
                end
            end
            S_OFF:
            begin
                off_next   = alu_res[15:0];
                state_next = S_USED;
            end
            S_USED:
            begin
                block_used_next = alu_res[15:0];
                state_next      = S_BFREE;
            end
            S_BFREE:
            begin
                block_free_next        = alu_res[15:0];
                pend_next.status       = ST_ARENA;
                pend_next.block_number = block_count_reg;
                pend_next.byte_offset  = off_reg;
                state_next             = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_data_next  = pend_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            in_use_map_reg   <= '0;
            hint_reg         <= '0;
            block_used_reg   <= '0;
            block_free_reg   <= '0;
            block_count_reg  <= '0;
            rsp_valid_reg    <= 1'b0;
            slots_in_use_reg <= RST_SLOTS_IN_USE;
            slot_bytes_reg   <= RST_SLOT_BYTES;
            block_bytes_reg  <= RST_BLOCK_BYTES;
            header_bytes_reg <= RST_HEADER_BYTES;
            max_blocks_reg   <= RST_MAX_BLOCKS;
        end
        else
        begin
            state_reg       <= state_next;
            in_use_map_reg  <= in_use_map_next;
            hint_reg        <= hint_next;
            block_used_reg  <= block_used_next;
            block_free_reg  <= block_free_next;
            block_count_reg <= block_count_next;
            rsp_valid_reg   <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SLOTS_IN_USE: slots_in_use_reg <= cfg_data[5:0];
                    CFG_SLOT_BYTES:   slot_bytes_reg   <= cfg_data[12:0];
                    CFG_BLOCK_BYTES:  block_bytes_reg  <= cfg_data;
                    CFG_HEADER_BYTES: header_bytes_reg <= cfg_data[5:0];
                    CFG_MAX_BLOCKS:   max_blocks_reg   <= cfg_data[7:0];
                    default:          max_blocks_reg   <= max_blocks_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        scan_ptr_reg <= scan_ptr_next;
        bytes_reg    <= bytes_next;
        need_reg     <= need_next;
        cap_reg      <= cap_next;
        off_reg      <= off_next;
        pend_reg     <= pend_next;
        rsp_data_reg <= rsp_data_next;
    end

    // scan never starts below the hint, and the hint holds during a scan
    a_scan_from_hint: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> scan_ptr_reg >= hint_reg)
        else $error("scan pointer below hint");

    // a slot found free is marked in use on the next cycle
    a_hit_marks: assert property (@(posedge clk) disable iff (!rst_n)
        scan_hit |=> in_use_map_reg[$past(scan_idx)])
        else $error("granted slot not marked");

    // an arena grant always lies in an opened block
    a_grant_block: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && pend_reg.status == ST_ARENA) |-> block_count_reg != 8'd0)
        else $error("arena grant without open block");

    // granted slot beats stay inside the pool
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_data_reg.status == ST_SLOT) |-> 7'(rsp_data_reg.slot) < NSLOTS7)
        else $error("granted slot out of pool");

endmodule

`default_nettype wire

[dv/tb_slot_cache_with_arena_fallback_core.sv]
// Testbench for the slot cache core: directed and random traffic against an allocator model.
module tb_slot_cache_with_arena_fallback_core;
    import sca_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 64;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS    = 141;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    req_t        req_data  = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    rsp_t        rsp_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = CFG_SLOTS_IN_USE;
    logic [15:0] cfg_data  = '0;

    slot_cache_with_arena_fallback_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // allocator model: registers
    logic [5:0]  m_slots       = RST_SLOTS_IN_USE;
    logic [12:0] m_slot_bytes  = RST_SLOT_BYTES;
    logic [15:0] m_block_bytes = RST_BLOCK_BYTES;
    logic [5:0]  m_header      = RST_HEADER_BYTES;
    logic [7:0]  m_max_blocks  = RST_MAX_BLOCKS;
    // allocator model: state
    logic [31:0] m_in_use    = '0;
    int unsigned m_hint      = 0;
    logic [15:0] m_blk_used  = '0;
    logic [15:0] m_blk_free  = '0;
    logic [7:0]  m_blk_count = '0;

    req_t req_backlog[$];
    rsp_t rsp_due[$];
    int   fails = 0;
    int   stuck_cycles = 0;
    logic req_beat = 1'b0;
    int   tx_gap_pct = 8;
    int   rx_gap_pct = 49;
    int   hold_asks = 0;
    int   hold_seen = 0;
    int   hold_left = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic rsp_t arena_carve(int unsigned bytes);
        int unsigned need;
        int unsigned cap;
        rsp_t r;
        need = bytes + TAG_BYTES;
        cap = (m_block_bytes > m_header) ? m_block_bytes - m_header : 0;
        r = '0;
        if (need > m_blk_free)
        begin
            if (need > cap)
            begin
                r.status = ST_TOO_LARGE;
                return r;
            end
            if (m_blk_count >= m_max_blocks)
            begin
                r.status = ST_NO_BLOCKS;
                return r;
            end
            m_blk_count = m_blk_count + 8'd1;
            m_blk_used = 16'(m_header);
            m_blk_free = cap[15:0];
        end
        r.status = ST_ARENA;
        r.block_number = m_blk_count;
        r.byte_offset = m_blk_used + TAG_BYTES;
        m_blk_used = m_blk_used + need[15:0];
        m_blk_free = m_blk_free - need[15:0];
        return r;
    endfunction

    // returns 0 when the request produces no response
    function automatic bit alloc_outcome(req_t q, output rsp_t r);
        int unsigned lim;
        int unsigned s;
        r = '0;
        case (q.opcode)
            OP_ALLOC_SLOT:
            begin
                lim = (m_slots < POOL_SLOTS_DEF) ? m_slots : POOL_SLOTS_DEF;
                // scan from the hint upward, no wrap
                for (s = m_hint; s < lim; s++)
                begin
                    if (!m_in_use[s])
                    begin
                        m_in_use[s] = 1'b1;
                        m_hint = s + 1;
                        r.status = ST_SLOT;
                        r.slot = s[4:0];
                        return 1'b1;
                    end
                end
                m_hint = lim;
                r = arena_carve(m_slot_bytes);
                return 1'b1;
            end
            OP_ALLOC_ARENA:
            begin
                r = arena_carve(q.req_bytes);
                return 1'b1;
            end
            OP_FREE_SLOT:
            begin
                m_in_use[q.slot_index] = 1'b0;
                if (32'(q.slot_index) < m_hint)
                    m_hint = q.slot_index;
                r.status = ST_FREED;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (rst_n && (!req_valid || req_beat))
        begin
            if (req_backlog.size() != 0 && $urandom_range(0, 99) >= tx_gap_pct)
            begin
                req_data <= req_backlog.pop_front();
                req_valid <= 1'b1;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // response ready, with an occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_asks != hold_seen)
        begin
            hold_seen = hold_asks;
            hold_left = RX_HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= rst_n && ($urandom_range(0, 99) >= rx_gap_pct);
    end

    // monitor: check responses, then predict on accepted requests
    always @(posedge clk)
    begin
        rsp_t want;
        req_beat <= req_valid && req_ready;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (rsp_due.size() == 0)
                begin
                    $error("response beat with nothing outstanding: %p", rsp_data);
                    fails++;
                end
                else
                begin
                    want = rsp_due.pop_front();
                    check_field("status", want.status, rsp_data.status);
                    check_field("slot", want.slot, rsp_data.slot);
                    check_field("block_number", want.block_number, rsp_data.block_number);
                    check_field("byte_offset", want.byte_offset, rsp_data.byte_offset);
                end
            end
            if (req_valid && req_ready)
            begin
                if (alloc_outcome(req_data, want))
                    rsp_due.push_back(want);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
                stuck_cycles <= 0;
            else if (stuck_cycles == WATCHDOG_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
            else
                stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_SLOTS_IN_USE: m_slots = val[5:0];
            CFG_SLOT_BYTES:   m_slot_bytes = val[12:0];
            CFG_BLOCK_BYTES:  m_block_bytes = val;
            CFG_HEADER_BYTES: m_header = val[5:0];
            CFG_MAX_BLOCKS:   m_max_blocks = val[7:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(int s, int sb, int bb, int hb, int mb);
        write_reg(CFG_SLOTS_IN_USE, 16'(s));
        write_reg(CFG_SLOT_BYTES, 16'(sb));
        write_reg(CFG_BLOCK_BYTES, 16'(bb));
        write_reg(CFG_HEADER_BYTES, 16'(hb));
        write_reg(CFG_MAX_BLOCKS, 16'(mb));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (req_backlog.size() != 0 || req_valid || rsp_due.size() != 0)
            @(posedge clk);
    endtask

    // an unused opcode may still be in flight after the last response
    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic push_item(logic [1:0] op, int bytes, int idx);
        req_t q;
        q.opcode = op;
        q.req_bytes = 16'(bytes);
        q.slot_index = 5'(idx);
        req_backlog.push_back(q);
    endtask

    function automatic req_t make_item(int unsigned span);
        req_t q;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            q.opcode = OP_ALLOC_SLOT;
        else if (pick < 65)
            q.opcode = OP_ALLOC_ARENA;
        else if (pick < 95)
            q.opcode = OP_FREE_SLOT;
        else
            q.opcode = OP_UNUSED;
        if ($urandom_range(0, 7) == 0)
            q.req_bytes = 16'($urandom_range(0, 65535));
        else
            q.req_bytes = 16'($urandom_range(0, m_block_bytes / 4));
        // frees mostly land inside the live pool
        if (span == 0 || $urandom_range(0, 3) == 0)
            q.slot_index = 5'($urandom_range(0, 31));
        else
            q.slot_index = 5'($urandom_range(0, span - 1));
        return q;
    endfunction

    initial
    begin
        int ph;
        int n;
        int headroom;
        int unsigned span;
        int s;
        int bb;
        int mb;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: slot grants, frees incl. double free, tag and block edges
        push_item(OP_ALLOC_SLOT, 0, 0);
        push_item(OP_ALLOC_SLOT, 0, 0);
        push_item(OP_ALLOC_SLOT, 0, 0);
        push_item(OP_FREE_SLOT, 0, 1);
        push_item(OP_FREE_SLOT, 0, 1);
        push_item(OP_FREE_SLOT, 65535, 31);
        push_item(OP_ALLOC_SLOT, 0, 0);
        push_item(OP_UNUSED, 65535, 31);
        push_item(OP_ALLOC_ARENA, 0, 0);
        push_item(OP_ALLOC_ARENA, 65535, 0);
        push_item(OP_ALLOC_ARENA, 65486, 0);
        push_item(OP_ALLOC_ARENA, 65487, 0);
        settle();
        // zero slots: every slot request spills to the arena until blocks run out
        program_regs(0, 4096, 65535, 0, 3);
        push_item(OP_ALLOC_SLOT, 0, 0);
        push_item(OP_ALLOC_SLOT, 0, 0);
        push_item(OP_ALLOC_ARENA, 65535, 0);
        push_item(OP_ALLOC_ARENA, 65533, 0);
        settle();
        // slot count above the pool clamps; header above block size leaves no room
        program_regs(63, 1, 40, 63, 0);
        push_item(OP_ALLOC_SLOT, 0, 0);
        push_item(OP_ALLOC_ARENA, 0, 0);
        push_item(OP_ALLOC_ARENA, 65535, 0);
        push_item(OP_FREE_SLOT, 0, 0);
        push_item(OP_ALLOC_SLOT, 0, 0);

        for (ph = 0; ph < 8; ph++)
        begin
            settle();
            if (ph == 3)
            begin
                tx_gap_pct = 49;
                rx_gap_pct = 8;
            end
            if (ph == 6)
            begin
                tx_gap_pct = 0;
                rx_gap_pct = 0;
            end
            headroom = m_blk_count + $urandom_range(1, 24);
            if (headroom > 255)
                headroom = 255;
            n = $urandom_range(0, 9);
            s = (n == 0) ? 0 : (n == 1) ? $urandom_range(33, 63) : $urandom_range(1, 32);
            bb = ($urandom_range(0, 3) == 0) ? $urandom_range(64, 65535)
                                             : $urandom_range(64, 1024);
            mb = (ph == 5) ? 1 : headroom;
            case (ph)
                0: program_regs(32, 64, 65500, 12, 255);
                1: program_regs(1, 1, 64, 0, headroom);
                2: program_regs(32, 4096, 65535, 63, headroom);
                default: program_regs(s, $urandom_range(1, 4096), bb, $urandom_range(0, 63), mb);
            endcase
            span = (m_slots < POOL_SLOTS_DEF) ? m_slots : POOL_SLOTS_DEF;
            for (n = 0; n < PHASE_ITEMS / 2; n++)
                req_backlog.push_back(make_item(span));
            if (ph == 1)
            begin
                // long receiver stall while requests keep coming
                @(posedge clk);
                hold_asks++;
            end
            if (ph == 4)
                drain();
            for (n = PHASE_ITEMS / 2; n < PHASE_ITEMS; n++)
                req_backlog.push_back(make_item(span));
        end
        settle();
        if (fails == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
